>>> sv/lds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants for the LED driver serial frame sender.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int GRID_COUNT = 16;
  localparam int GRID_W     = $clog2(GRID_COUNT + 1);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CMD_DATA_SET   = 8'h40;
  localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;

  localparam int HDR_END  = 19;
  localparam int DATA_END = 7;
  localparam int TRL_END  = 11;
  localparam int POS_W    = 5;

  typedef enum logic [1:0] {
    SYM_DATA  = 2'd0,
    SYM_START = 2'd1,
    SYM_STOP  = 2'd2
  } sym_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_TRL
  } back_state_t;

  typedef struct packed {
    logic       hdr;
    logic       trl;
    logic [7:0] data;
  } cmd_t;

endpackage
`default_nettype wire

>>> sv/lds_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lds_front
// Accepts display bytes, tracks the open frame and tags each byte with
// header and trailer flags before queueing it.
// ----------------------------------------------------------------------------
module lds_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [7:0] display_byte
  input  wire logic          in_tlast,   // last_byte
  input  wire logic          q_full,
  output logic               q_push,
  output lds_pkg::cmd_t      q_cmd
);
  import lds_pkg::*;

  logic              frame_open_r, frame_open_nxt;
  logic [GRID_W-1:0] grid_cnt_r, grid_cnt_nxt;
  logic [GRID_W-1:0] cnt_base, cnt_inc;
  logic              closing;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    cnt_base = frame_open_r ? grid_cnt_r : '0;
    cnt_inc  = (cnt_base < GRID_W'(GRID_COUNT)) ? cnt_base + GRID_W'(1) : cnt_base;
    closing  = in_tlast || (cnt_inc == GRID_W'(GRID_COUNT));

    q_cmd.hdr  = !frame_open_r;
    q_cmd.trl  = closing;
    q_cmd.data = in_tdata;

    frame_open_nxt = frame_open_r;
    grid_cnt_nxt   = grid_cnt_r;
    if (q_push) begin
      frame_open_nxt = !closing;
      grid_cnt_nxt   = closing ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      grid_cnt_r   <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      grid_cnt_r   <= grid_cnt_nxt;
    end
  end

  a_closed_frame_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_open_r |-> grid_cnt_r == '0)
    else $error("grid count nonzero with no open frame");

  a_grid_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    grid_cnt_r < GRID_W'(GRID_COUNT))
    else $error("grid count reached limit without closing");

endmodule
`default_nettype wire

>>> sv/lds_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lds_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module lds_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lds_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               rd_valid,
  output lds_pkg::cmd_t      rd_cmd
);
  import lds_pkg::*;

  cmd_t           entry_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCW'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue written while full");

endmodule
`default_nettype wire

>>> sv/lds_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lds_back
// Walks each queued command through its flagged header, data and flagged trailer
// symbols, driving one symbol per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module lds_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [2:0]    cfg_wr_data,
  input  wire logic          q_valid,
  input  wire lds_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,  // [1:0] symbol, [2] bit_value, [7:3] zero
  output logic               out_tlast   // last
);
  import lds_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [2:0]       bright_r;
  logic             out_valid_r;
  sym_t             out_sym_r;
  logic             out_bit_r, out_last_r;

  logic       adv, emit, done;
  sym_t       sym;
  logic       bit_v;
  logic [2:0] bidx2, bidx4;
  logic [7:0] trl_byte;

  assign adv      = !out_valid_r || out_tready;
  assign bidx2    = pos_r[2:0] - 3'd2;
  assign bidx4    = pos_r[2:0] + 3'd4;
  assign trl_byte = CMD_DISPLAY_ON | {5'b0, bright_r};

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cur_nxt   = cur_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    done      = 1'b0;
    sym       = SYM_DATA;
    bit_v     = 1'b0;

    case (state_r)
      ST_HDR: begin
        if (adv) begin
          emit = 1'b1;
          case (pos_r) inside
            5'd0, 5'd10: sym = SYM_STOP;
            5'd1, 5'd11: sym = SYM_START;
            [5'd2:5'd9]: bit_v = CMD_DATA_SET[bidx2];
            default:     bit_v = CMD_ADDRESS[bidx4];
          endcase
          if (pos_r == POS_W'(HDR_END)) begin
            state_nxt = ST_DATA;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      ST_DATA: begin
        if (adv) begin
          emit  = 1'b1;
          bit_v = cur_r.data[pos_r[2:0]];
          if (pos_r == POS_W'(DATA_END)) begin
            if (cur_r.trl) begin
              state_nxt = ST_TRL;
              pos_nxt   = '0;
            end else begin
              done = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      ST_TRL: begin
        if (adv) begin
          emit = 1'b1;
          case (pos_r) inside
            5'd0, 5'd10: sym = SYM_STOP;
            5'd1, 5'd11: sym = SYM_START;
            default:     bit_v = trl_byte[bidx2];
          endcase
          if (pos_r == POS_W'(TRL_END)) begin
            done = 1'b1;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if ((state_r == ST_IDLE) || done) begin
      if (q_valid) begin
        q_pop     = 1'b1;
        cur_nxt   = q_cmd;
        state_nxt = q_cmd.hdr ? ST_HDR : ST_DATA;
        pos_nxt   = '0;
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      bright_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (cfg_wr_en) begin
        bright_r <= cfg_wr_data;
      end
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_sym_r  <= sym;
      out_bit_r  <= bit_v;
      out_last_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_bit_r, out_sym_r};
  assign out_tlast  = out_last_r;

  a_hdr_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HDR |-> cur_r.hdr)
    else $error("header sequence for a command without header flag");

  a_trl_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TRL |-> cur_r.trl)
    else $error("trailer sequence for a command without trailer flag");

  a_last_not_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_sym_r != SYM_STOP)
    else $error("final symbol of a byte is a stop condition");

endmodule
`default_nettype wire

>>> sv/led_driver_serial_frame_sender.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_driver_serial_frame_sender
// Turns display bytes into two-wire LED driver write symbols.
// ----------------------------------------------------------------------------
// Each accepted byte produces its line symbols one per cycle on the output
// stream: 8 symbols for a byte inside an open frame, 28 when it opens a
// frame, 20 when it closes one and 40 when it does both. The symbol
// sequencer sets the rate, one symbol per cycle while out_tready is high; a
// byte reaching an idle sequencer is loaded before its first symbol is sent. A
// two-entry queue in front of the sequencer lets in_tready stay high while
// earlier bytes are still being sent. The user must write brightness through
// cfg_wr_en and cfg_wr_data while no transfer is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module led_driver_serial_frame_sender (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data,  // brightness
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] display_byte
  input  wire logic       in_tlast,     // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // [1:0] symbol, [2] bit_value, [7:3] zero
  output logic            out_tlast     // last
);
  import lds_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  lds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  lds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_cmd   (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (head_cmd)
  );

  lds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire
